/* hw/rtl/mbrrc_pkg.sv */
package mbrrc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  // Input command codes.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Frame and CRC constants.
  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned CNT_W     = 3;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;
  } out_item_t;

endpackage

/* hw/rtl/modbus_read_response_checker_unit.sv */
// Channel | Ports                          | Direction | Item
// input   | in_valid, in_ready, in_item    | in        | command and received byte
// result  | out_valid, out_ready, out_item | out       | status, index, word, last
// config  | cfg_we, cfg_wdata              | in        | register count, no wait
//
// An input item is accepted whenever in_ready is high; in_ready drops only while both job queue entries are full.
// A frame end or timeout becomes one job; the back part sends one result per cycle from it while out_ready is high.
// Reset is synchronous and active low; the register count returns to three.
// A stalled result waits in the output register while the front keeps taking bytes until the job queue is full.
module modbus_read_response_checker_unit import mbrrc_pkg::*; #(
  parameter int MAX_REGISTERS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int JOB_W = 2 + IDX_W + 16 * MAX_REGISTERS;

  logic             push_valid;
  logic [JOB_W-1:0] push_data;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  logic [JOB_W-1:0] head_data;

  // Front part: handshake, CRC and data capture.
  mbrrc_front #(
    .MAX_REGISTERS(MAX_REGISTERS),
    .JOB_W(JOB_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push_valid(push_valid),
    .push_data(push_data),
    .q_full(q_full)
  );

  // Job queue between the two parts.
  mbrrc_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push_valid),
    .push_data(push_data),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head_data(head_data)
  );

  // Back part: result sequencing.
  mbrrc_back #(
    .MAX_REGISTERS(MAX_REGISTERS),
    .JOB_W(JOB_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_valid(head_valid),
    .head_data(head_data),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

endmodule

/* hw/rtl/mbrrc_front.sv */
module mbrrc_front import mbrrc_pkg::*; #(
  parameter int MAX_REGISTERS = 4,
  parameter int JOB_W = 2 + 2 + 16 * 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic             push_valid,
  output logic [JOB_W-1:0] push_data,
  input  logic             q_full
);

  localparam int IDX_W  = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int POS_W  = $clog2(2 * MAX_REGISTERS + 5);
  localparam int DIDX_W = $clog2(2 * MAX_REGISTERS);
  localparam int DATA_W = 16 * MAX_REGISTERS;

  // One byte folded into the CRC, least significant bit first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       data_r [2*MAX_REGISTERS];

  logic             accept;
  logic [3:0]       cnt_ext;
  logic [3:0]       n_w;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] data_off;
  logic             data_wr;
  logic [15:0]      rx_crc;
  status_t          job_status;
  logic [IDX_W-1:0] job_last_idx;
  logic [DATA_W-1:0] job_data;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Register count clamped to the supported range.
  always_comb begin
    cnt_ext = {1'b0, cnt_r};
    if (cnt_ext == 4'd0) begin
      n_w = 4'd1;
    end else if (cnt_ext > 4'(MAX_REGISTERS)) begin
      n_w = 4'(MAX_REGISTERS);
    end else begin
      n_w = cnt_ext;
    end
  end

  // Position of the CRC low byte; the byte after it closes the frame.
  assign end_pos      = POS_W'(HDR_BYTES) + POS_W'({n_w, 1'b0});
  assign data_off     = pos_r - POS_W'(HDR_BYTES);
  assign data_wr      = accept && (in_item.cmd == CMD_BYTE) && (pos_r < end_pos) &&
                        (pos_r >= POS_W'(HDR_BYTES)) &&
                        (data_off < POS_W'(2 * MAX_REGISTERS));
  assign rx_crc       = {in_item.rx_byte, crc_lo_r};
  assign job_last_idx = IDX_W'(n_w - 4'd1);

  // Classify the item and advance the frame state.
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    push_valid = 1'b0;
    job_status = ST_OK;
    if (accept) begin
      if (in_item.cmd == CMD_TIMEOUT) begin
        push_valid = 1'b1;
        job_status = ST_TIMEOUT;
        pos_nxt    = '0;
        crc_nxt    = CRC_INIT;
        crc_lo_nxt = 8'h00;
      end else if (pos_r < end_pos) begin
        crc_nxt = crc_fold(crc_r, in_item.rx_byte);
        pos_nxt = pos_r + POS_W'(1);
      end else if (pos_r == end_pos) begin
        crc_lo_nxt = in_item.rx_byte;
        pos_nxt    = pos_r + POS_W'(1);
      end else begin
        push_valid = 1'b1;
        job_status = (rx_crc == crc_r) ? ST_OK : ST_CRC_ERR;
        pos_nxt    = '0;
        crc_nxt    = CRC_INIT;
        crc_lo_nxt = 8'h00;
      end
    end
  end

  // Snapshot of the stored data as big-endian register words.
  always_comb begin
    for (int i = 0; i < MAX_REGISTERS; i++) begin
      job_data[i*16 +: 16] = {data_r[2*i], data_r[2*i+1]};
    end
  end

  assign push_data = {job_status, job_last_idx, job_data};

  // Frame state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CNT_W'(3);
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= 8'h00;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Data byte store.
  always_ff @(posedge clk) begin
    if (data_wr) begin
      data_r[data_off[DIDX_W-1:0]] <= in_item.rx_byte;
    end
  end

endmodule

/* hw/rtl/mbrrc_fifo.sv */
module mbrrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from an empty queue");
`endif

endmodule

/* hw/rtl/mbrrc_back.sv */
module mbrrc_back import mbrrc_pkg::*; #(
  parameter int MAX_REGISTERS = 4,
  parameter int JOB_W = 2 + 2 + 16 * 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  logic [JOB_W-1:0] head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int IDX_W  = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int DATA_W = 16 * MAX_REGISTERS;

  status_t          head_status;
  logic [IDX_W-1:0] head_last_idx;
  logic [DATA_W-1:0] head_words;

  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             load;
  logic             job_done;
  logic [IDX_W+1:0] idx_ext;

  assign head_status   = status_t'(head_data[JOB_W-1 -: 2]);
  assign head_last_idx = head_data[DATA_W +: IDX_W];
  assign head_words    = head_data[DATA_W-1:0];

  // A result loads whenever a job is waiting and the output register is free or being emptied.
  assign load     = head_valid && (!out_valid_r || out_ready);
  assign job_done = (head_status != ST_OK) || (idx_r == head_last_idx);
  assign pop      = load && job_done;
  assign idx_ext  = (IDX_W + 2)'(idx_r);

  // Build the next result from the job at the queue head.
  always_comb begin
    out_item_nxt.status = head_status;
    if (head_status == ST_OK) begin
      out_item_nxt.reg_index = idx_ext[1:0];
      out_item_nxt.reg_value = head_words[idx_r*16 +: 16];
      out_item_nxt.last      = (idx_r == head_last_idx);
    end else begin
      out_item_nxt.reg_index = 2'd0;
      out_item_nxt.reg_value = 16'h0000;
      out_item_nxt.last      = 1'b1;
    end
  end

  // Word counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= pop ? '0 : idx_r + IDX_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded result not presented");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r <= head_last_idx))
    else $error("word index ran past the frame's last register");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status != ST_OK)) |-> out_item_r.last)
    else $error("error result not marked last");
`endif

endmodule

/* sim/modbus_read_response_checker_unit_tb.sv */
`timescale 1ns / 1ps

module modbus_read_response_checker_unit_tb import mbrrc_pkg::*; ();

  localparam int MAX_REGS     = 4;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 280;
  localparam int PHASE_ITEMS  = 30;
  localparam int REPORT_MAX   = 10;

  // Predicts the results of a response frame and checks the words that come out.
  class frame_scoreboard;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       position;
    logic [15:0]      crc;
    logic [7:0]       crc_low;
    logic [7:0]       data_bytes [2*MAX_REGS];
    out_item_t        expected_words [$];
    int               mismatches;

    function new();
      count_reg  = 3'd3;
      mismatches = 0;
      foreach (data_bytes[i]) data_bytes[i] = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      position = 4'd0;
      crc      = CRC_INIT;
      crc_low  = 8'h00;
    endfunction

    // One byte of the reflected CRC-16, least significant bit first.
    static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        if (r[0]) begin
          r = (r >> 1) ^ CRC_POLY;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    // Out-of-range counts are clamped to the legal range.
    function int regs_in_use();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > MAX_REGS) n = MAX_REGS;
      return n;
    endfunction

    function int frame_len();
      return int'(HDR_BYTES) + 2 * regs_in_use() + 2;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void add_expect(status_t s, int idx, logic [15:0] v, logic lst);
      out_item_t e;
      e.status    = s;
      e.reg_index = idx[1:0];
      e.reg_value = v;
      e.last      = lst;
      expected_words.push_back(e);
    endfunction

    // Advances the frame state by one accepted item.
    function void take_rx_item(in_item_t it);
      int n;
      int len;
      int p;
      n   = regs_in_use();
      len = frame_len();
      p   = int'(position);
      if (it.cmd == CMD_TIMEOUT) begin
        add_expect(ST_TIMEOUT, 0, 16'h0000, 1'b1);
        clear_frame();
      end else if (p < len - 2) begin
        crc = crc_fold(crc, it.rx_byte);
        if (p >= int'(HDR_BYTES) && p - int'(HDR_BYTES) < 2 * MAX_REGS) begin
          data_bytes[p - int'(HDR_BYTES)] = it.rx_byte;
        end
        position = position + 4'd1;
      end else if (p == len - 2) begin
        crc_low  = it.rx_byte;
        position = position + 4'd1;
      end else begin
        // The current byte is the CRC high byte and closes the frame.
        if ({it.rx_byte, crc_low} != crc) begin
          add_expect(ST_CRC_ERR, 0, 16'h0000, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            add_expect(ST_OK, i, {data_bytes[2*i], data_bytes[2*i+1]}, (i == n - 1));
          end
        end
        clear_frame();
      end
    endfunction

    function void report(string what, out_item_t e, out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%s: expected st=%0d idx=%0d val=%h last=%0d, got st=%0d idx=%0d val=%h last=%0d",
                 what, e.status, e.reg_index, e.reg_value, e.last,
                 got.status, got.reg_index, got.reg_value, got.last);
      end
    endfunction

    function void check_result_word(out_item_t got);
      out_item_t e;
      if (expected_words.size() == 0) begin
        e = '0;
        report("unexpected result", e, got);
        return;
      end
      e = expected_words.pop_front();
      if (got.status != e.status || got.reg_index != e.reg_index ||
          got.reg_value != e.reg_value || got.last != e.last) begin
        report("result mismatch", e, got);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  frame_scoreboard  frame_sb;
  int               items_accepted;
  int               cycle_count;
  bit               in_burst;
  bit               out_burst;

  modbus_read_response_checker_unit #(
    .MAX_REGISTERS(MAX_REGS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      frame_sb.check_result_word(out_item);
    end
  end

  // The result side drops out_ready for a random stall before each item, except in output bursts.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sends one item after a random gap; returns at the falling edge after acceptance.
  task automatic send_item(logic cmd, logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_item.cmd     = cmd;
    in_item.rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_sb.take_rx_item(in_item);
    items_accepted++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b);
  endtask

  task automatic send_timeout();
    send_item(CMD_TIMEOUT, 8'($urandom));
  endtask

  // Completes the current frame from wherever it stands, optionally with a bad CRC.
  task automatic close_frame(bit corrupt);
    bit          hit_low;
    logic [7:0]  mask;
    hit_low = corrupt && ($urandom_range(0, 1) == 1);
    mask    = 8'($urandom_range(1, 255));
    while (int'(frame_sb.position) < frame_sb.frame_len() - 2) begin
      send_byte(8'($urandom));
    end
    if (int'(frame_sb.position) == frame_sb.frame_len() - 2) begin
      send_byte(frame_sb.crc[7:0] ^ (hit_low ? mask : 8'h00));
    end else begin
      hit_low = 1'b0;
    end
    send_byte(frame_sb.crc[15:8] ^ ((corrupt && !hit_low) ? mask : 8'h00));
  endtask

  // Sends a fixed header and data, then a CRC that is right or has one of its bytes flipped.
  task automatic send_fixed_frame(logic [7:0] bytes [], bit corrupt);
    foreach (bytes[i]) send_byte(bytes[i]);
    close_frame(corrupt);
  endtask

  // Waits until every result has come, plus a margin for work still inside.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (frame_sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    frame_sb.count_reg = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random sequence: mostly good frames, some broken ones and noise.
  task automatic run_sequence();
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      close_frame(1'b0);
    end else if (r == 6) begin
      close_frame(1'b1);
    end else if (r == 7) begin
      k = $urandom_range(1, frame_sb.frame_len() - 1);
      repeat (k) send_byte(8'($urandom));
      send_timeout();
    end else if (r == 8) begin
      send_timeout();
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] count_plan [8];
    logic [7:0]       good_bytes [];
    logic [7:0]       bad_bytes [];
    logic [CNT_W-1:0] v;
    int               phase;
    int               phase_end;
    int               k;

    count_plan     = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd3, 3'd4};
    frame_sb       = new();
    items_accepted = 0;
    cycle_count    = 0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: timeout while idle, then good and bad frames at the largest count.
    send_item(CMD_TIMEOUT, 8'hFF);
    wait_idle();
    write_count(3'd4);
    good_bytes = '{8'hFF, 8'h03, 8'h08, 8'h00, 8'h00, 8'hFF, 8'hFF,
                   8'h80, 8'h01, 8'h7F, 8'hFE};
    send_fixed_frame(good_bytes, 1'b0);
    bad_bytes = '{8'h00, 8'h00, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80,
                  8'hC3, 8'h3C, 8'h0F, 8'hF0};
    send_fixed_frame(bad_bytes, 1'b1);

    // Random phases, each under its own register count; some end mid-frame
    // so the next count takes over a frame already in progress.
    phase = 0;
    while (items_accepted < ITEM_TARGET) begin
      v = (phase < 8) ? count_plan[phase] : CNT_W'($urandom_range(0, 7));
      wait_idle();
      write_count(v);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      phase_end = items_accepted + PHASE_ITEMS;
      while (items_accepted < phase_end) run_sequence();
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, frame_sb.frame_len() - 1);
        repeat (k) send_byte(8'($urandom));
      end
      phase++;
    end

    wait_idle();
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mbrrc_pkg.sv
hw/rtl/mbrrc_front.sv
hw/rtl/mbrrc_fifo.sv
hw/rtl/mbrrc_back.sv
hw/rtl/modbus_read_response_checker_unit.sv
sim/modbus_read_response_checker_unit_tb.sv
